// File: sv/trz_pkg.sv
// shared types and constants for the triangle rasterizer with depth buffer
// no dependencies
package trz_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam int DEPTH_W = 18;
	localparam logic signed [DEPTH_W-1:0] DEPTH_FAR = 18'sd131071;
	localparam logic [17:0] INV_MAX = 18'd262143;
	localparam int ONE_Q14 = 16384;

	typedef logic [5:0] coord_t;
	typedef logic signed [DEPTH_W-1:0] depth_t;

endpackage

// File: sv/trz_ram.sv
// generic single-port-write, single-read synchronous ram with registered read
// no dependencies
module trz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/trz_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on nothing; used for reciprocals and the 1/w interpolation
module trz_div #(
	parameter int NW = 40,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;

	assign shifted = {r_q[DW-1:0], n_q[NW-1]};
	assign diff = shifted - {1'b0, d_q};
	assign quo = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (run_q) begin
			if (!diff[DW]) begin
				r_q <= diff;
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

endmodule

// File: sv/triangle_raster_zbuffer.sv
// top level: triangle scan engine with an external-style depth ram
// depends on trz_pkg, trz_ram and trz_div
// A load forms the three reciprocals of w one after another with a bit-serial
// divider at one quotient bit a cycle. A step on a covered pixel uses the same
// divider to form the interpolated 1/w; then the depth ram is read and, where
// the depth test passes, written back. Any other step on an active scan skips
// the divider, and a step while idle gives a result with no pixel write.
// After reset the depth ram is cleared one entry a cycle, every entry in turn,
// while in_stall is high. Every transaction gives exactly one result, held in
// an output register. The next transaction is accepted only after that result
// has been taken.
module triangle_raster_zbuffer #(
	parameter int SCREEN_WIDTH = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [5:0]  ax,
	input  logic [5:0]  ay,
	input  logic [15:0] aw,
	input  logic [5:0]  bx,
	input  logic [5:0]  by,
	input  logic [15:0] bw,
	input  logic [5:0]  cx,
	input  logic [5:0]  cy,
	input  logic [15:0] cw,
	input  logic [31:0] color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_pixel,
	output logic [5:0]  pixel_x,
	output logic [5:0]  pixel_y,
	output logic [31:0] pixel_color,
	output logic signed [17:0] pixel_depth,
	output logic        busy_res
);

	localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = $clog2(NPIX);
	localparam int NW = 40;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RECIP = 4'd2;
	localparam logic [3:0] ST_RWAIT = 4'd3;
	localparam logic [3:0] ST_EDGE  = 4'd4;
	localparam logic [3:0] ST_SUM   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_DWAIT = 4'd7;
	localparam logic [3:0] ST_TEST  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [AW:0] clr_q;
	logic [1:0] ridx_q;
	logic [15:0] w_q [3];
	logic [5:0] vx_q [3];
	logic [5:0] vy_q [3];
	logic [17:0] inv_q [3];
	logic signed [13:0] area_q;
	logic [5:0] x0_q, x1_q, y0_q, y1_q, sx_q, sy_q, px_q, py_q;
	logic [31:0] color_q;
	logic active_q;
	logic signed [13:0] e_q [3];
	logic [NW-1:0] num_q;
	logic [13:0] ar_q;
	logic signed [17:0] dep_q;
	logic cov_q;

	// vertex math, on latched registers and on the input vertices at a load
	function automatic logic signed [13:0] edge_f(input logic [5:0] x0, input logic [5:0] y0,
		input logic [5:0] x1, input logic [5:0] y1, input logic [5:0] qx, input logic [5:0] qy);
		logic signed [13:0] a, b, c, d;
		a = $signed({1'b0, x1}) - $signed({1'b0, x0});
		b = $signed({1'b0, qy}) - $signed({1'b0, y0});
		c = $signed({1'b0, y1}) - $signed({1'b0, y0});
		d = $signed({1'b0, qx}) - $signed({1'b0, x0});
		return a * b - c * d;
	endfunction

	// divider
	logic div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [15:0] div_den;
	trz_div #(.NW(NW), .DW(16)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	// depth ram
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [17:0] ram_wdata, ram_rdata;
	trz_ram #(.WIDTH(18), .DEPTH(NPIX)) u_depth (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic [AW-1:0] pix_addr;
	logic onscreen;
	logic in_acc, out_acc;
	logic signed [13:0] ne [3];
	logic [13:0] abs_area;
	logic [NW-1:0] iw;
	logic signed [19:0] dfull;
	logic signed [17:0] dsat;

	assign pix_addr = AW'(({{(AW){1'b0}}, py_q} * AW'(SCREEN_WIDTH)) + AW'(px_q));
	assign onscreen = (32'(px_q) < SCREEN_WIDTH) && (32'(py_q) < SCREEN_HEIGHT);
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign abs_area = area_q[13] ? 14'(-area_q) : 14'(area_q);
	assign ram_raddr = pix_addr;

	always_comb begin
		ne[0] = edge_f(vx_q[1], vy_q[1], vx_q[2], vy_q[2], px_q, py_q);
		ne[1] = edge_f(vx_q[2], vy_q[2], vx_q[0], vy_q[0], px_q, py_q);
		ne[2] = edge_f(vx_q[0], vy_q[0], vx_q[1], vy_q[1], px_q, py_q);
		if (area_q[13]) begin
			ne[0] = -ne[0];
			ne[1] = -ne[1];
			ne[2] = -ne[2];
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		if (state_q == ST_RECIP) begin
			div_start = 1'b1;
			div_num = NW'((64'd1 << 22) + 64'(w_q[ridx_q] >> 1));
			div_den = w_q[ridx_q];
		end else if (state_q == ST_DIV) begin
			div_start = 1'b1;
			div_num = num_q + NW'(ar_q >> 1);
			div_den = 16'(ar_q);
		end
	end

	assign iw = div_quo;
	assign dfull = 20'sd16384 - ((|iw[NW-1:19]) ? 20'sd262143 : $signed({1'b0, iw[18:0]}));
	assign dsat = (dfull < -20'sd131072) ? -18'sd131072 :
		(dfull > 20'sd131071) ? 18'sd131071 : 18'(dfull);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = pix_addr;
		ram_wdata = 18'(trz_pkg::DEPTH_FAR);
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q[AW-1:0];
		end else if (state_q == ST_TEST && cov_q && $signed(dep_q) <= $signed(ram_rdata)) begin
			ram_we = 1'b1;
			ram_wdata = dep_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ridx_q <= '0;
			active_q <= 1'b0;
			out_valid <= 1'b0;
			area_q <= '0;
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				inv_q[i] <= '0;
				w_q[i] <= '0;
				e_q[i] <= '0;
			end
			x0_q <= '0; x1_q <= '0; y0_q <= '0; y1_q <= '0;
			sx_q <= '0; sy_q <= '0;
			px_q <= '0; py_q <= '0;
			color_q <= '0;
			num_q <= '0;
			ar_q <= '0;
			dep_q <= '0;
			cov_q <= 1'b0;
			write_pixel <= 1'b0;
			pixel_x <= '0; pixel_y <= '0;
			pixel_color <= '0; pixel_depth <= '0;
			busy_res <= 1'b0;
		end else begin
			if (out_acc) out_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(NPIX - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (command == trz_pkg::CMD_LOAD) begin
							vx_q[0] <= ax; vy_q[0] <= ay;
							vx_q[1] <= bx; vy_q[1] <= by;
							vx_q[2] <= cx; vy_q[2] <= cy;
							w_q[0] <= aw; w_q[1] <= bw; w_q[2] <= cw;
							color_q <= color;
							x0_q <= (ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx);
							x1_q <= (ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx);
							y0_q <= (ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy);
							y1_q <= (ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy);
							sx_q <= (ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx);
							sy_q <= (ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy);
							area_q <= edge_f(ax, ay, bx, by, cx, cy);
							ridx_q <= '0;
							active_q <= 1'b1;
							state_q <= ST_RECIP;
						end else if (!active_q) begin
							write_pixel <= 1'b0;
							pixel_x <= '0; pixel_y <= '0;
							pixel_color <= '0; pixel_depth <= '0;
							busy_res <= 1'b0;
							out_valid <= 1'b1;
						end else begin
							px_q <= sx_q;
							py_q <= sy_q;
							state_q <= ST_EDGE;
						end
					end
				end
				ST_RECIP: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (div_done) begin
						if (w_q[ridx_q] == 16'd0) inv_q[ridx_q] <= '0;
						else if (|div_quo[NW-1:18]) inv_q[ridx_q] <= trz_pkg::INV_MAX;
						else inv_q[ridx_q] <= div_quo[17:0];
						if (ridx_q == 2'd2) begin
							write_pixel <= 1'b0;
							pixel_x <= '0; pixel_y <= '0;
							pixel_color <= '0; pixel_depth <= '0;
							busy_res <= 1'b1;
							out_valid <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							ridx_q <= ridx_q + 1'b1;
							state_q <= ST_RECIP;
						end
					end
				end
				ST_EDGE: begin
					for (int i = 0; i < 3; i++) e_q[i] <= ne[i];
					ar_q <= abs_area;
					cov_q <= (area_q != 0) && (inv_q[0] != 0) && (inv_q[1] != 0) &&
						(inv_q[2] != 0) && onscreen && !ne[0][13] && !ne[1][13] && !ne[2][13];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					num_q <= NW'(32'(e_q[0]) * 32'(inv_q[0])) + NW'(32'(e_q[1]) * 32'(inv_q[1]))
						+ NW'(32'(e_q[2]) * 32'(inv_q[2]));
					state_q <= cov_q ? ST_DIV : ST_TEST;
				end
				ST_DIV: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						dep_q <= dsat;
						if (iw == '0) cov_q <= 1'b0;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					write_pixel <= ram_we;
					pixel_x <= ram_we ? px_q : '0;
					pixel_y <= ram_we ? py_q : '0;
					pixel_color <= ram_we ? color_q : '0;
					pixel_depth <= ram_we ? dep_q : '0;
					if (sx_q < x1_q) begin
						sx_q <= sx_q + 1'b1;
						busy_res <= 1'b1;
					end else if (sy_q < y1_q) begin
						sx_q <= x0_q;
						sy_q <= sy_q + 1'b1;
						busy_res <= 1'b1;
					end else begin
						active_q <= 1'b0;
						busy_res <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/trz_checker.sv
// port-level checker for the triangle rasterizer, bound to the top level
// depends on triangle_raster_zbuffer
module trz_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic write_pixel,
	input logic [5:0] pixel_x,
	input logic signed [17:0] pixel_depth
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x))
		else $error("stalled result changed");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !(in_valid && !in_stall))
		else $error("transaction accepted back to back");

	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_pixel |-> pixel_depth == 18'sd0)
		else $error("depth shown without a write");

	a_pending_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open with result pending");

endmodule

bind triangle_raster_zbuffer trz_checker u_trz_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .write_pixel(write_pixel),
	.pixel_x(pixel_x), .pixel_depth(pixel_depth)
);

// File: tb/testbench.sv
// self-checking testbench for triangle_raster_zbuffer: loads and scans triangles
// depends on trz_pkg and the triangle_raster_zbuffer rtl
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic        wr;
		logic [5:0]  x;
		logic [5:0]  y;
		logic [31:0] col;
		logic signed [17:0] dep;
		logic        busy;
	} pixel_result_t;

	localparam int SW = 64;
	localparam int SH = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic command = trz_pkg::CMD_STEP;
	logic [5:0] ax = 0, ay = 0, bx = 0, by = 0, cx = 0, cy = 0;
	logic [15:0] aw = 0, bw = 0, cw = 0;
	logic [31:0] color = 0;
	logic out_valid;
	logic out_stall = 0;
	logic write_pixel;
	logic [5:0] pixel_x, pixel_y;
	logic [31:0] pixel_color;
	logic signed [17:0] pixel_depth;
	logic busy_res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	pixel_result_t pending_pixels[$];

	// predictor state
	int depth_map[SW*SH];
	int vtx_x[3], vtx_y[3];
	int inv_w[3];
	int area2;
	int bx0, bx1, by0, by1;
	int sx, sy;
	logic [31:0] tri_color;
	bit scanning;

	triangle_raster_zbuffer dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int edge_val(int x0, int y0, int x1, int y1, int px, int py);
		return (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
	endfunction

	function automatic int recip_w(int w);
		longint r;
		if (w == 0)
			return 0;
		r = ((64'd1 << 22) + (w >> 1)) / w;
		return (r > trz_pkg::INV_MAX) ? int'(trz_pkg::INV_MAX) : int'(r);
	endfunction

	function automatic pixel_result_t predict_pixel(logic cmd, int x0, int y0, int w0,
			int x1, int y1, int w1, int x2, int y2, int w2, logic [31:0] c);
		pixel_result_t r;
		int px, py, e0, e1, e2, ar;
		longint num, iw, d;
		r = '0;
		if (cmd == trz_pkg::CMD_LOAD) begin
			x0 = x0 & 63; y0 = y0 & 63; w0 = w0 & 'hffff;
			x1 = x1 & 63; y1 = y1 & 63; w1 = w1 & 'hffff;
			x2 = x2 & 63; y2 = y2 & 63; w2 = w2 & 'hffff;
			vtx_x = '{x0, x1, x2};
			vtx_y = '{y0, y1, y2};
			inv_w = '{recip_w(w0), recip_w(w1), recip_w(w2)};
			tri_color = c;
			area2 = edge_val(x0, y0, x1, y1, x2, y2);
			bx0 = x0 < x1 ? (x0 < x2 ? x0 : x2) : (x1 < x2 ? x1 : x2);
			bx1 = x0 > x1 ? (x0 > x2 ? x0 : x2) : (x1 > x2 ? x1 : x2);
			by0 = y0 < y1 ? (y0 < y2 ? y0 : y2) : (y1 < y2 ? y1 : y2);
			by1 = y0 > y1 ? (y0 > y2 ? y0 : y2) : (y1 > y2 ? y1 : y2);
			sx = bx0;
			sy = by0;
			scanning = 1;
			r.busy = 1;
			return r;
		end
		if (!scanning)
			return r;
		px = sx;
		py = sy;
		if (area2 != 0 && inv_w[0] != 0 && inv_w[1] != 0 && inv_w[2] != 0
				&& px < SW && py < SH) begin
			e0 = edge_val(vtx_x[1], vtx_y[1], vtx_x[2], vtx_y[2], px, py);
			e1 = edge_val(vtx_x[2], vtx_y[2], vtx_x[0], vtx_y[0], px, py);
			e2 = edge_val(vtx_x[0], vtx_y[0], vtx_x[1], vtx_y[1], px, py);
			ar = area2;
			if (ar < 0) begin
				ar = -ar; e0 = -e0; e1 = -e1; e2 = -e2;
			end
			if (e0 >= 0 && e1 >= 0 && e2 >= 0) begin
				num = longint'(e0) * inv_w[0] + longint'(e1) * inv_w[1]
					+ longint'(e2) * inv_w[2];
				iw = (num + (ar >> 1)) / ar;
				if (iw != 0) begin
					d = trz_pkg::ONE_Q14 - iw;
					if (d < -131072)
						d = -131072;
					if (d > 131071)
						d = 131071;
					if (d <= depth_map[py*SW+px]) begin
						depth_map[py*SW+px] = int'(d);
						r.wr = 1;
						r.x = 6'(px);
						r.y = 6'(py);
						r.col = tri_color;
						r.dep = 18'(d);
					end
				end
			end
		end
		if (sx < bx1)
			sx++;
		else if (sy < by1) begin
			sx = bx0;
			sy++;
		end else
			scanning = 0;
		r.busy = scanning;
		return r;
	endfunction

	task automatic send_item(logic cmd, int x0, int y0, int w0, int x1, int y1, int w1,
			int x2, int y2, int w2, logic [31:0] c);
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1;
		command <= cmd;
		ax <= 6'(x0); ay <= 6'(y0); aw <= 16'(w0);
		bx <= 6'(x1); by <= 6'(y1); bw <= 16'(w1);
		cx <= 6'(x2); cy <= 6'(y2); cw <= 16'(w2);
		color <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_pixels.push_back(predict_pixel(cmd, x0, y0, w0, x1, y1, w1, x2, y2, w2, c));
		in_valid <= 0;
	endtask

	task automatic load_tri(int x0, int y0, int w0, int x1, int y1, int w1,
			int x2, int y2, int w2, logic [31:0] c);
		send_item(trz_pkg::CMD_LOAD, x0, y0, w0, x1, y1, w1, x2, y2, w2, c);
	endtask

	task automatic step_scan(int n);
		for (int i = 0; i < n; i++)
			send_item(trz_pkg::CMD_STEP, $urandom_range(63), $urandom_range(63), $urandom,
				$urandom_range(63), $urandom_range(63), $urandom,
				$urandom_range(63), $urandom_range(63), $urandom, $urandom);
	endtask

	task automatic finish_scan();
		int guard;
		guard = 0;
		while (scanning && guard < 200) begin
			step_scan(1);
			guard++;
		end
	endtask

	task automatic test_directed();
		step_scan(1);
		load_tri(0, 0, 256, 3, 0, 256, 0, 3, 256, 32'hffff_ffff);
		finish_scan();
		load_tri(63, 63, 65535, 60, 63, 1, 63, 60, 65535, 32'h0);
		finish_scan();
		load_tri(2, 2, 0, 5, 2, 256, 2, 5, 256, 32'h1234_5678);
		finish_scan();
		load_tri(1, 1, 512, 4, 4, 512, 6, 6, 512, 32'hdead_beef);
		finish_scan();
		load_tri(10, 10, 128, 10, 13, 300, 13, 10, 700, 32'h5555_aaaa);
		step_scan(3);
		load_tri(11, 11, 40000, 14, 11, 20, 11, 14, 1000, 32'haaaa_5555);
		finish_scan();
		step_scan(2);
	endtask

	task automatic test_random(int n_items);
		int sent, x0, y0, span;
		sent = 0;
		while (sent < n_items) begin
			span = ($urandom_range(9) == 0) ? 12 : 4;
			x0 = $urandom_range(63);
			y0 = $urandom_range(63);
			load_tri(x0, y0, $urandom_range(3) == 0 ? $urandom : $urandom_range(4096, 16),
				(x0 + $urandom_range(span)) % 64, (y0 + $urandom_range(span)) % 64,
				$urandom_range(7) == 0 ? 0 : $urandom_range(65535, 1),
				(x0 + $urandom_range(span)) % 64, (y0 + $urandom_range(span)) % 64,
				$urandom_range(4096, 1), $urandom);
			sent++;
			if ($urandom_range(5) == 0) begin
				step_scan(2);
				sent += 2;
			end else
				while (scanning && sent < n_items) begin
					step_scan(1);
					sent++;
				end
		end
		finish_scan();
	endtask

	task automatic test_backpressure();
		hold_reqs++;
		load_tri(20, 20, 256, 26, 20, 512, 20, 26, 768, 32'h0f0f_0f0f);
		finish_scan();
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		pixel_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			quiet_cycles <= 0;
			if (pending_pixels.size() == 0) begin
				$error("unexpected transaction on result port");
				fail_count++;
			end else begin
				e = pending_pixels.pop_front();
				if (write_pixel !== e.wr) begin
					$error("write_pixel exp %0d got %0d", e.wr, write_pixel); fail_count++;
				end
				if (pixel_x !== e.x) begin
					$error("pixel_x exp %0d got %0d", e.x, pixel_x); fail_count++;
				end
				if (pixel_y !== e.y) begin
					$error("pixel_y exp %0d got %0d", e.y, pixel_y); fail_count++;
				end
				if (pixel_color !== e.col) begin
					$error("pixel_color exp %h got %h", e.col, pixel_color); fail_count++;
				end
				if (pixel_depth !== e.dep) begin
					$error("pixel_depth exp %0d got %0d", e.dep, pixel_depth); fail_count++;
				end
				if (busy_res !== e.busy) begin
					$error("busy_res exp %0d got %0d", e.busy, busy_res); fail_count++;
				end
			end
		end else if (arst_n && !(in_valid && !in_stall))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
	end

	// receiver stall
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog, also covers the depth ram clear after reset
	always @(posedge clk) begin
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SW*SH; i++)
			depth_map[i] = 131071;
		scanning = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 25; recv_idle_pct = 87;
		test_random(220);
		test_backpressure();
		send_idle_pct = 87; recv_idle_pct = 25;
		test_random(220);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(220);
		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_pixels.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
